FILE: hw/rtl/beacon_frame_parser_assert.svh
// assertion macros shared by the beacon frame parser modules
`ifndef BEACON_FRAME_PARSER_ASSERT_SVH
`define BEACON_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BFP_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("beacon frame parser: check failed");

// next-cycle implication, clocked on clk, off during reset
`define BFP_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("beacon frame parser: check failed");

`endif

FILE: hw/rtl/bfp_pkg.sv
// shared types and status codes of the beacon frame parser
package bfp_pkg;

	// result status codes
	localparam logic [2:0] ST_FOUND      = 3'd0;
	localparam logic [2:0] ST_NO_SSID    = 3'd1;
	localparam logic [2:0] ST_SHORT      = 3'd2;
	localparam logic [2:0] ST_BAD_VER    = 3'd3;
	localparam logic [2:0] ST_BAD_RTLEN  = 3'd4;
	localparam logic [2:0] ST_NOT_BEACON = 3'd5;
	localparam logic [2:0] ST_TRUNCATED  = 3'd6;
	localparam logic [2:0] ST_TOO_LONG   = 3'd7;

	// per-packet summary handed from the parser to the output side
	typedef struct packed {
		logic        valid;
		logic [2:0]  status;
		logic [47:0] bssid;
		logic        hidden;
		logic        bank;
	} desc_t;

endpackage

FILE: hw/rtl/beacon_frame_parser.sv
// top level of the beacon frame parser
// Usage: a captured packet enters one byte per word on the input channel
// (data_byte, end_of_packet on the final byte), radiotap header first.
// A word moves when valid is high and stall is low.
// Throughput: one byte per cycle. The final byte of a packet is held off
// (in_stall) only while the previous packet's result words are still going
// out; the output side sends n+1 words for a packet with an n-byte SSID.
// The final byte's summary is registered in the drain, then the status
// word in the output register; SSID byte words follow one per cycle while
// unstalled; last flagged by last_of_run. Error statuses give one word.
// The SSID store is a two-bank memory, so the next packet fills one bank
// while the other drains; its read port feeds the output register.
// Reset clears the parser and the output valid at once; there is no
// clearing pass. When the receiver stalls, the output word holds and the
// parser keeps taking bytes of the next packet up to its final byte.
module beacon_frame_parser #(
	parameter int MAX_SSID_BYTES = 32,
	parameter int POSITION_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [47:0] bssid,
	output logic [5:0]  ssid_length,
	output logic        ssid_hidden,
	output logic        is_ssid_byte,
	output logic [7:0]  ssid_byte,
	output logic        last_of_run
);

	localparam int CNT_W = $clog2(MAX_SSID_BYTES + 1);
	localparam int IDX_W = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;
	localparam int AW    = IDX_W + 1;

	bfp_pkg::desc_t   desc;
	logic [CNT_W-1:0] desc_count;
	logic             desc_ready;
	logic             accept;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;

	// hold the final byte until the output side can take its summary
	assign in_stall = in_valid && end_of_packet && !desc_ready;
	assign accept   = in_valid && !in_stall;

	bfp_parser #(
		.MAX_SSID_BYTES(MAX_SSID_BYTES),
		.POSITION_BITS (POSITION_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.end_of_packet(end_of_packet),
		.desc         (desc),
		.desc_count   (desc_count),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	bfp_drain #(
		.MAX_SSID_BYTES(MAX_SSID_BYTES)
	) u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc        (desc),
		.desc_count  (desc_count),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.desc_ready  (desc_ready),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.bssid       (bssid),
		.ssid_length (ssid_length),
		.ssid_hidden (ssid_hidden),
		.is_ssid_byte(is_ssid_byte),
		.ssid_byte   (ssid_byte),
		.last_of_run (last_of_run)
	);

endmodule

FILE: hw/rtl/bfp_parser.sv
// byte-wise radiotap / beacon header parser and element walker
`include "beacon_frame_parser_assert.svh"

module bfp_parser #(
	parameter int MAX_SSID_BYTES = 32,
	parameter int POSITION_BITS  = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  accept,
	input  logic [7:0]                                            data_byte,
	input  logic                                                  end_of_packet,
	output bfp_pkg::desc_t                                        desc,
	output logic [$clog2(MAX_SSID_BYTES + 1)-1:0]                 desc_count,
	output logic                                                  wr_en,
	output logic [((MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1):0] wr_addr,
	output logic [7:0]                                            wr_data
);

	localparam int CNT_W = $clog2(MAX_SSID_BYTES + 1);
	localparam int IDX_W = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;
	localparam int POS_W = POSITION_BITS;
	localparam int NX_W  = POS_W + 1;
	localparam int CMP_W = ((POS_W > 16) ? POS_W : 16) + 2;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_IE_ID  = 3'd1;
	localparam logic [2:0] PH_IE_LEN = 3'd2;
	localparam logic [2:0] PH_SKIP   = 3'd3;
	localparam logic [2:0] PH_SSID   = 3'd4;
	localparam logic [2:0] PH_LONG   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      hdr_q, hdr_d;
	logic [7:0]       fc_q, fc_d;
	logic [47:0]      bssid_q, bssid_d;
	logic [NX_W-1:0]  next_q, next_d;
	logic [7:0]       eid_q, eid_d;
	logic [2:0]       phase_q, phase_d;
	logic [2:0]       err_q, err_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             nz_q, nz_d;
	logic             bank_q;

	logic [CMP_W-1:0] p_ext, hdr_ext, len_ext, hdrn_ext;
	logic [NX_W-1:0]  p_inc;
	logic             at_elem_end;
	logic [2:0]       st;

	assign p_ext       = CMP_W'(pos_q);
	assign hdr_ext     = CMP_W'(hdr_q);
	assign p_inc       = {1'b0, pos_q} + NX_W'(1);
	assign at_elem_end = (p_inc == next_q);

	// next parser state for the incoming byte
	always_comb begin
		pos_d   = pos_q;
		hdr_d   = hdr_q;
		fc_d    = fc_q;
		bssid_d = bssid_q;
		next_d  = next_q;
		eid_d   = eid_q;
		phase_d = phase_q;
		err_d   = err_q;
		cnt_d   = cnt_q;
		nz_d    = nz_q;
		wr_en   = 1'b0;
		wr_addr = {bank_q, cnt_q[IDX_W-1:0]};
		wr_data = data_byte;
		if (pos_q != POS_MAX) begin
			pos_d = pos_q + POS_W'(1);
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == '0 && data_byte != 8'h00) begin
						phase_d = PH_DONE;
						err_d   = bfp_pkg::ST_BAD_VER;
					end else begin
						if (pos_q == POS_W'(2)) hdr_d = {8'h00, data_byte};
						if (pos_q == POS_W'(3)) hdr_d = {data_byte, hdr_q[7:0]};
						if (pos_q >= POS_W'(4)) begin
							if (p_ext == hdr_ext) fc_d = data_byte;
							if (p_ext >= hdr_ext + CMP_W'(16) &&
							    p_ext <= hdr_ext + CMP_W'(21))
								bssid_d = {bssid_q[39:0], data_byte};
							if (p_ext == hdr_ext + CMP_W'(35)) begin
								phase_d = PH_IE_ID;
								next_d  = p_inc;
							end
						end
					end
				end
				PH_IE_ID: begin
					eid_d   = data_byte;
					phase_d = PH_IE_LEN;
				end
				PH_IE_LEN: begin
					next_d = p_inc + NX_W'(data_byte);
					if (eid_q == 8'h00) begin
						cnt_d = '0;
						nz_d  = 1'b0;
						priority if (data_byte == 8'h00) begin
							phase_d = PH_DONE;
							err_d   = bfp_pkg::ST_FOUND;
						end else if (9'(data_byte) > 9'(MAX_SSID_BYTES)) begin
							phase_d = PH_LONG;
						end else begin
							phase_d = PH_SSID;
						end
					end else begin
						phase_d = (data_byte == 8'h00) ? PH_IE_ID : PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (at_elem_end) phase_d = PH_IE_ID;
				end
				PH_SSID: begin
					if (cnt_q < CNT_W'(MAX_SSID_BYTES)) begin
						wr_en = accept;
						cnt_d = cnt_q + CNT_W'(1);
					end
					if (data_byte != 8'h00) nz_d = 1'b1;
					if (at_elem_end) begin
						phase_d = PH_DONE;
						err_d   = bfp_pkg::ST_FOUND;
					end
				end
				PH_LONG: begin
					if (at_elem_end) begin
						phase_d = PH_DONE;
						err_d   = bfp_pkg::ST_TOO_LONG;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// packet verdict from the state after this byte
	assign len_ext  = CMP_W'(pos_d);
	assign hdrn_ext = CMP_W'(hdr_d);

	always_comb begin
		priority if (len_ext < CMP_W'(8))
			st = bfp_pkg::ST_SHORT;
		else if (phase_d == PH_DONE && err_d == bfp_pkg::ST_BAD_VER)
			st = bfp_pkg::ST_BAD_VER;
		else if (hdrn_ext < CMP_W'(8) || hdrn_ext > len_ext)
			st = bfp_pkg::ST_BAD_RTLEN;
		else if (len_ext < hdrn_ext + CMP_W'(36))
			st = bfp_pkg::ST_SHORT;
		else if (fc_d[1:0] != 2'b00 || fc_d[3:2] != 2'b00 || fc_d[7:4] != 4'h8)
			st = bfp_pkg::ST_NOT_BEACON;
		else if (phase_d == PH_DONE)
			st = err_d;
		else if (phase_d == PH_IE_ID)
			st = bfp_pkg::ST_NO_SSID;
		else
			st = bfp_pkg::ST_TRUNCATED;
	end

	// summary of the finished packet
	always_comb begin
		desc.valid  = accept && end_of_packet;
		desc.status = st;
		desc.bssid  = (st == bfp_pkg::ST_FOUND || st == bfp_pkg::ST_NO_SSID) ?
		              bssid_d : 48'h0;
		desc.hidden = (st == bfp_pkg::ST_FOUND) && (cnt_d == '0 || !nz_d);
		desc.bank   = bank_q;
		desc_count  = (st == bfp_pkg::ST_FOUND) ? cnt_d : '0;
	end

	// parser registers, cleared at packet end, bank bit toggled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= '0;
			fc_q    <= '0;
			bssid_q <= '0;
			next_q  <= '0;
			eid_q   <= '0;
			phase_q <= PH_HEADER;
			err_q   <= '0;
			cnt_q   <= '0;
			nz_q    <= 1'b0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_packet) begin
				pos_q   <= '0;
				hdr_q   <= '0;
				fc_q    <= '0;
				bssid_q <= '0;
				next_q  <= '0;
				eid_q   <= '0;
				phase_q <= PH_HEADER;
				err_q   <= '0;
				cnt_q   <= '0;
				nz_q    <= 1'b0;
				bank_q  <= ~bank_q;
			end else begin
				pos_q   <= pos_d;
				hdr_q   <= hdr_d;
				fc_q    <= fc_d;
				bssid_q <= bssid_d;
				next_q  <= next_d;
				eid_q   <= eid_d;
				phase_q <= phase_d;
				err_q   <= err_d;
				cnt_q   <= cnt_d;
				nz_q    <= nz_d;
			end
		end
	end

	`BFP_ASSERT_NEXT(a_clear_after_end, accept && end_of_packet, pos_q == '0 && phase_q == PH_HEADER)

endmodule

FILE: hw/rtl/bfp_drain.sv
// ssid byte store and result word sequencer with output register
`include "beacon_frame_parser_assert.svh"

module bfp_drain #(
	parameter int MAX_SSID_BYTES = 32
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  bfp_pkg::desc_t                                        desc,
	input  logic [$clog2(MAX_SSID_BYTES + 1)-1:0]                 desc_count,
	input  logic                                                  wr_en,
	input  logic [((MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1):0] wr_addr,
	input  logic [7:0]                                            wr_data,
	output logic                                                  desc_ready,
	input  logic                                                  out_stall,
	output logic                                                  out_valid,
	output logic [2:0]                                            status,
	output logic [47:0]                                           bssid,
	output logic [5:0]                                            ssid_length,
	output logic                                                  ssid_hidden,
	output logic                                                  is_ssid_byte,
	output logic [7:0]                                            ssid_byte,
	output logic                                                  last_of_run
);

	localparam int CNT_W = $clog2(MAX_SSID_BYTES + 1);
	localparam int IDX_W = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;
	localparam int AW    = IDX_W + 1;

	// two banks: one drains while the next packet fills the other
	logic [7:0] mem [0:(2**AW)-1];

	logic             busy_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	logic [2:0]       st_q;
	logic [47:0]      bssid_q;
	logic             hidden_q;
	logic             bank_q;

	logic             out_valid_q;
	logic [2:0]       out_status_q;
	logic [47:0]      out_bssid_q;
	logic [5:0]       out_len_q;
	logic             out_hidden_q;
	logic             out_is_ssid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic             out_load;
	logic             last_item;
	logic [CNT_W-1:0] k;
	logic [AW-1:0]    rd_addr;

	assign out_load   = busy_q && (!out_valid_q || !out_stall);
	assign last_item  = (idx_q == n_q);
	assign desc_ready = !busy_q || (out_load && last_item);
	assign k          = idx_q - CNT_W'(1);
	assign rd_addr    = {bank_q, k[IDX_W-1:0]};

	// ssid store write port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (desc.valid) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (out_load) begin
				if (last_item) busy_q <= 1'b0;
				else           idx_q  <= idx_q + CNT_W'(1);
			end
			if (out_load)       out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// packet summary held while its words go out
	always_ff @(posedge clk) begin
		if (desc.valid) begin
			n_q      <= desc_count;
			st_q     <= desc.status;
			bssid_q  <= desc.bssid;
			hidden_q <= desc.hidden;
			bank_q   <= desc.bank;
		end
	end

	// output word register, ssid bytes come straight from the store read
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_is_ssid_q <= (idx_q != '0);
			out_last_q    <= last_item;
			if (idx_q == '0) begin
				out_status_q <= st_q;
				out_bssid_q  <= bssid_q;
				out_len_q    <= 6'(n_q);
				out_hidden_q <= hidden_q;
				out_byte_q   <= 8'h00;
			end else begin
				out_status_q <= bfp_pkg::ST_FOUND;
				out_bssid_q  <= 48'h0;
				out_len_q    <= 6'd0;
				out_hidden_q <= 1'b0;
				out_byte_q   <= mem[rd_addr];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign bssid        = out_bssid_q;
	assign ssid_length  = out_len_q;
	assign ssid_hidden  = out_hidden_q;
	assign is_ssid_byte = out_is_ssid_q;
	assign ssid_byte    = out_byte_q;
	assign last_of_run  = out_last_q;

	`BFP_ASSERT_IMP(a_desc_when_ready, desc.valid, desc_ready)
	`BFP_ASSERT_IMP(a_idx_in_range, busy_q, idx_q <= n_q)
	`BFP_ASSERT_IMP(a_error_single_word, out_valid_q && !out_is_ssid_q && out_status_q != bfp_pkg::ST_FOUND, out_last_q)

endmodule

FILE: dv/beacon_frame_parser_check.sv
// checker for the beacon frame parser: predicts result words and compares them
`timescale 1ns / 100ps

module beacon_frame_parser_check #(
	parameter int MAX_SSID = 32,
	parameter int POS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [47:0] bssid,
	input  logic [5:0]  ssid_length,
	input  logic        ssid_hidden,
	input  logic        is_ssid_byte,
	input  logic [7:0]  ssid_byte,
	input  logic        last_of_run,
	output int          errors,
	output int          pending
);

	localparam int unsigned POS_MAX = (1 << POS_BITS) - 1;
	localparam int SIDX_W = (MAX_SSID > 1) ? $clog2(MAX_SSID) : 1;
	localparam logic [3:0] BEACON_SUBTYPE = 4'h8;
	localparam int MAX_SHOWN = 10;

	typedef enum logic [2:0] {
		WALK_HEADER, WALK_ELEM_ID, WALK_ELEM_LEN, WALK_SKIP, WALK_SSID, WALK_LONG, WALK_DONE
	} walk_phase_e;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] bssid;
		logic [5:0]  ssid_length;
		logic        hidden;
		logic        is_byte;
		logic [7:0]  sbyte;
		logic        last;
	} result_word_t;

	// per-packet parse state
	logic [POS_BITS-1:0] byte_pos;
	logic [15:0]         hdr_len;
	logic [7:0]          fc_low;
	logic [47:0]         bssid_acc;
	logic [POS_BITS:0]   next_start;
	logic [7:0]          elem_id;
	walk_phase_e         phase;
	logic [2:0]          end_code;
	logic [7:0]          ssid_mem [MAX_SSID];
	logic [5:0]          ssid_cnt;
	logic                ssid_nz;

	result_word_t expected_words[$];
	int words_seen;

	function automatic void clear_packet();
		byte_pos   = '0;
		hdr_len    = '0;
		fc_low     = '0;
		bssid_acc  = '0;
		next_start = '0;
		elem_id    = '0;
		phase      = WALK_HEADER;
		end_code   = bfp_pkg::ST_FOUND;
		ssid_cnt   = '0;
		ssid_nz    = 1'b0;
	endfunction

	// append one predicted word at the tail of the queue
	function automatic void queue_word(input result_word_t w);
		expected_words.insert(expected_words.size(), w);
	endfunction

	function automatic void close_walk(input logic [2:0] code);
		end_code = code;
		phase    = WALK_DONE;
	endfunction

	// one byte through the header checks and the element walk
	function automatic void parse_packet_byte(input int unsigned p, input logic [7:0] b);
		int unsigned hl;
		hl = int'(hdr_len);
		case (phase)
			WALK_HEADER: begin
				if (p == 0 && b != 8'd0) begin
					close_walk(bfp_pkg::ST_BAD_VER);
				end else begin
					if (p == 2) hdr_len[7:0] = b;
					if (p == 3) hdr_len[15:8] = b;
					if (p >= 4) begin
						if (p == hl) fc_low = b;
						if (p >= hl + 16 && p <= hl + 21) bssid_acc = {bssid_acc[39:0], b};
						if (p == hl + 35) begin
							phase      = WALK_ELEM_ID;
							next_start = (POS_BITS + 1)'(p + 1);
						end
					end
				end
			end
			WALK_ELEM_ID: begin
				elem_id = b;
				phase   = WALK_ELEM_LEN;
			end
			WALK_ELEM_LEN: begin
				next_start = (POS_BITS + 1)'(p + 1 + b);
				if (elem_id == 8'd0) begin
					ssid_cnt = '0;
					ssid_nz  = 1'b0;
					if (b == 8'd0) close_walk(bfp_pkg::ST_FOUND);
					else if (b > MAX_SSID) phase = WALK_LONG;
					else phase = WALK_SSID;
				end else if (b == 8'd0) begin
					phase = WALK_ELEM_ID;
				end else begin
					phase = WALK_SKIP;
				end
			end
			WALK_SKIP: begin
				if (p + 1 == next_start) phase = WALK_ELEM_ID;
			end
			WALK_SSID: begin
				if (ssid_cnt < MAX_SSID) begin
					ssid_mem[ssid_cnt[SIDX_W-1:0]] = b;
					ssid_cnt++;
				end
				if (b != 8'd0) ssid_nz = 1'b1;
				if (p + 1 == next_start) close_walk(bfp_pkg::ST_FOUND);
			end
			WALK_LONG: begin
				if (p + 1 == next_start) close_walk(bfp_pkg::ST_TOO_LONG);
			end
			default: ;
		endcase
	endfunction

	// status of a packet of len parsed bytes, in priority order
	function automatic logic [2:0] packet_verdict(input int unsigned len);
		int unsigned hl;
		hl = int'(hdr_len);
		if (len < 8) return bfp_pkg::ST_SHORT;
		if (phase == WALK_DONE && end_code == bfp_pkg::ST_BAD_VER) return bfp_pkg::ST_BAD_VER;
		if (hl < 8 || hl > len) return bfp_pkg::ST_BAD_RTLEN;
		if (len < hl + 36) return bfp_pkg::ST_SHORT;
		if (fc_low[1:0] != 2'd0 || fc_low[3:2] != 2'd0 || fc_low[7:4] != BEACON_SUBTYPE)
			return bfp_pkg::ST_NOT_BEACON;
		if (phase == WALK_DONE) return end_code;
		if (phase == WALK_ELEM_ID) return bfp_pkg::ST_NO_SSID;
		return bfp_pkg::ST_TRUNCATED;
	endfunction

	// status word and ssid byte words for a finished packet
	function automatic void predict_packet_end();
		logic [2:0] st;
		int n;
		result_word_t w;
		st = packet_verdict(int'(byte_pos));
		n = (st == bfp_pkg::ST_FOUND) ? int'(ssid_cnt) : 0;
		w = '0;
		w.status      = st;
		w.bssid       = (st == bfp_pkg::ST_FOUND || st == bfp_pkg::ST_NO_SSID) ?
		                bssid_acc : 48'd0;
		w.ssid_length = 6'(n);
		w.hidden      = (st == bfp_pkg::ST_FOUND && (ssid_cnt == 0 || !ssid_nz));
		w.last        = (n == 0);
		queue_word(w);
		for (int k = 0; k < n; k++) begin
			w = '0;
			w.is_byte = 1'b1;
			w.sbyte   = ssid_mem[SIDX_W'(k)];
			w.last    = (k == n - 1);
			queue_word(w);
		end
		clear_packet();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_word_t want, got;
		if (!arst_n) begin
			clear_packet();
			expected_words.delete();
			errors     = 0;
			pending    = 0;
			words_seen = 0;
		end else begin
			// input word: advance the parser, predict on the final byte
			if (in_valid && !in_stall) begin
				if (byte_pos < POS_MAX) begin
					parse_packet_byte(int'(byte_pos), data_byte);
					byte_pos++;
				end
				if (end_of_packet) predict_packet_end();
			end
			// output word: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				got = {status, bssid, ssid_length, ssid_hidden, is_ssid_byte, ssid_byte,
					last_of_run};
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display({"word %0d: none expected, got st=%0d bssid=%h len=%0d",
							" hid=%b ssid=%b byte=%h last=%b"},
							words_seen, got.status, got.bssid, got.ssid_length,
							got.hidden, got.is_byte, got.sbyte, got.last);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= MAX_SHOWN) begin
							$display({"word %0d: expected st=%0d bssid=%h len=%0d",
								" hid=%b ssid=%b byte=%h last=%b"},
								words_seen, want.status, want.bssid, want.ssid_length,
								want.hidden, want.is_byte, want.sbyte, want.last);
							$display({"word %0d: actual   st=%0d bssid=%h len=%0d",
								" hid=%b ssid=%b byte=%h last=%b"},
								words_seen, got.status, got.bssid, got.ssid_length,
								got.hidden, got.is_byte, got.sbyte, got.last);
						end
					end
				end
				words_seen++;
			end
			pending = expected_words.size();
		end
	end

endmodule

FILE: dv/beacon_frame_parser_test.sv
// testbench top for the beacon frame parser: packet stimulus, flow control, verdict
`timescale 1ns / 100ps

module beacon_frame_parser_test;

	localparam int MAX_SSID      = 32;
	localparam int POS_BITS      = 16;
	localparam int CYCLE_LIMIT   = 20_000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [7:0] FC_BEACON   = 8'h80;
	localparam logic [7:0] FC_QOS_DATA = 8'h88;

	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_e;
	typedef enum logic {FILL_RANDOM, FILL_ZERO} fill_e;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic [7:0]  data_byte     = 8'd0;
	logic        end_of_packet = 1'b0;
	logic        out_stall     = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  status;
	logic [47:0] bssid;
	logic [5:0]  ssid_length;
	logic        ssid_hidden;
	logic        is_ssid_byte;
	logic [7:0]  ssid_byte;
	logic        last_of_run;
	int          errors;
	int          pending;

	logic [7:0] pkt[$];
	int burst_left = 0;
	int gap_left   = 0;
	int cycles     = 0;
	rx_mode_e rx_mode = RX_FREE;
	int rx_left = 0;
	int rx_tick = 0;

	beacon_frame_parser #(
		.MAX_SSID_BYTES(MAX_SSID),
		.POSITION_BITS (POS_BITS)
	) dut (.*);

	beacon_frame_parser_check #(
		.MAX_SSID(MAX_SSID),
		.POS_BITS(POS_BITS)
	) parse_check (.*);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("beacon_frame_parser: mismatch");
			$finish;
		end
	end

	// receiver stall, switching between free, random, periodic and heavy stretches
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(10, 60);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_FREE:     out_stall <= 1'b0;
			RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
			RX_PERIODIC: out_stall <= ((rx_tick % 7) < 3);
			default:     out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	function automatic logic [47:0] rand_mac();
		return 48'({$urandom, $urandom});
	endfunction

	// append one byte to the packet under construction
	task automatic add_byte(input logic [7:0] b);
		pkt.insert(pkt.size(), b);
	endtask

	task automatic push_random(input int n);
		repeat (n) add_byte(8'($urandom));
	endtask

	// radiotap version, pad and little-endian length
	task automatic put_radiotap(input int hl);
		add_byte(8'h00);
		add_byte(8'($urandom));
		add_byte(hl[7:0]);
		add_byte(hl[15:8]);
	endtask

	// radiotap header of length hl, 24-byte beacon header and 12 fixed bytes
	task automatic put_frame(input int hl, input logic [7:0] fc, input logic [47:0] mac);
		put_radiotap(hl);
		push_random(hl - 4);
		add_byte(fc);
		push_random(15);
		for (int i = 5; i >= 0; i--) add_byte(mac[i*8 +: 8]);
		push_random(14);
	endtask

	task automatic put_elem(input logic [7:0] id, input int len, input fill_e fill);
		add_byte(id);
		add_byte(len[7:0]);
		repeat (len) add_byte((fill == FILL_ZERO) ? 8'd0 : 8'($urandom));
	endtask

	// one word on the input channel, with bursts and gaps; called at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eop);
		while (gap_left > 0) begin
			in_valid      = 1'b0;
			data_byte     = 8'($urandom);
			end_of_packet = 1'($urandom);
			gap_left--;
			@(negedge clk);
		end
		in_valid      = 1'b1;
		data_byte     = b;
		end_of_packet = eop;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (burst_left <= 1) begin
			burst_left = $urandom_range(1, 40);
			gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
		pkt.delete();
	endtask

	// hold the sender until every predicted word has come out
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// packet too short for any header
		push_random(1);
		send_packet();

		// radiotap version other than zero
		add_byte(8'hff);
		push_random(7);
		send_packet();

		// radiotap length below the minimum, then past the end of the packet
		put_radiotap(5);
		push_random(4);
		send_packet();
		put_radiotap(100);
		push_random(4);
		send_packet();

		// radiotap header fine but frame header and fixed fields cut short
		put_radiotap(8);
		push_random(12);
		send_packet();

		// data frame instead of a beacon
		put_frame(8, FC_QOS_DATA, rand_mac());
		send_packet();

		// ssid of full length, then wait for every result word
		put_frame(8, FC_BEACON, rand_mac());
		put_elem(8'd0, MAX_SSID, FILL_RANDOM);
		send_packet();
		drain();

		// element id as the last byte
		put_frame(8, FC_BEACON, rand_mac());
		put_elem(8'd5, 2, FILL_RANDOM);
		add_byte(8'd0);
		send_packet();

		drain();
		if (errors == 0)
			$display("beacon_frame_parser: match");
		else
			$display("beacon_frame_parser: mismatch");
		$finish;
	end

endmodule
